### sv/ali_pkg.sv
// shared types and codes for the positional insert/delete list
package ali_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int DATA_W        = 32;
   localparam int POS_W         = 6;
   localparam int MODE_W        = 2;
   localparam int STATUS_W      = 3;
   localparam int COUNT_W       = 7;
   localparam int REQ_TDATA_W   = 40;
   localparam int RSP_TDATA_W   = 48;
   localparam int RSP_PAD_W     = RSP_TDATA_W - STATUS_W - DATA_W - COUNT_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_READ   = 2'd2,
      MODE_READ_ALT = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic              ins_en;
      logic              del_en;
      logic [DATA_W-1:0] value;
      logic [POS_W-1:0]  pos;
   } cell_ctrl_type;

endpackage

### sv/ali_cell.sv
// one list slot: holds an entry, shifts up or down with its neighbors
module ali_cell #(
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  ali_pkg::cell_ctrl_type        ctrl,
   input  logic                          cell_valid,
   input  logic [ali_pkg::DATA_W-1:0]    left_entry,
   input  logic [ali_pkg::DATA_W-1:0]    right_entry,
   input  logic                          hit_in,
   output logic                          hit_out,
   output logic [ali_pkg::DATA_W-1:0]    entry
);

   localparam logic [ali_pkg::POS_W-1:0] IDX = ali_pkg::POS_W'(INDEX);

   logic [ali_pkg::DATA_W-1:0] entry_ff;
   logic [ali_pkg::DATA_W-1:0] entry_in;

   // hit_out: first match lies at or below this slot
   assign hit_out = hit_in | (cell_valid && (entry_ff == ctrl.value));
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en) begin
         if (ctrl.pos == IDX) begin
            entry_in = ctrl.value;
         end else if (IDX > ctrl.pos) begin
            entry_in = left_entry;
         end
      end else if (ctrl.del_en && hit_out) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### sv/array_list_insert_delete.sv
// packed ordered list with positional insert, delete-first-match and read
//
//   group   dir   tdata fields (low to high)          tuser / tlast
//   req_    in    mode[2], value[32], position[6]     none
//   rsp_    out   status[3], data_out[32], count[7]   none
//
// one transaction per cycle while the output register is empty or being drained:
// every slot compares and shifts in parallel, so an accepted request finishes in
// the cycle it is taken and its result sits in the output register from the next cycle.
// the first-match search ripples combinationally through the row of slots.
// reset clears the count and the output valid; slot contents need no reset.
// req_tready stays high while the output register is empty or being drained.
module array_list_insert_delete #(
   parameter int DEPTH = ali_pkg::DEFAULT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // mode, value, position
   input  logic [ali_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status, data_out, count, zero pad
   output logic [ali_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int CW    = $clog2(DEPTH + 1);
   localparam int IW    = $clog2(DEPTH);
   localparam int CMP_W = (CW > ali_pkg::POS_W) ? CW : ali_pkg::POS_W;

   logic [ali_pkg::MODE_W-1:0]   req_mode;
   logic [ali_pkg::DATA_W-1:0]   req_value;
   logic [ali_pkg::POS_W-1:0]    req_pos;

   assign req_mode  = req_tdata[ali_pkg::MODE_W-1:0];
   assign req_value = req_tdata[ali_pkg::MODE_W +: ali_pkg::DATA_W];
   assign req_pos   = req_tdata[ali_pkg::MODE_W + ali_pkg::DATA_W +: ali_pkg::POS_W];

   logic [CW-1:0]                count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ali_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ali_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [CW-1:0]                rsp_count_ff;

   logic                         req_fire;
   logic                         is_ins, is_del;
   logic                         list_empty, list_full;
   logic [CMP_W-1:0]             pos_ext, cnt_ext;
   logic                         op_ok;
   ali_pkg::cell_ctrl_type       ctrl;

   logic [ali_pkg::DATA_W-1:0]   entry_q [DEPTH];
   logic [DEPTH:0]               hit_chain;
   logic [DEPTH-1:0]             cell_valid;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign is_ins     = (req_mode == ali_pkg::MODE_INSERT);
   assign is_del     = (req_mode == ali_pkg::MODE_DELETE);
   assign list_empty = (count_ff == '0);
   assign list_full  = (count_ff >= CW'(DEPTH));
   assign pos_ext    = CMP_W'(req_pos);
   assign cnt_ext    = CMP_W'(count_ff);

   always_comb begin
      rsp_status_in = ali_pkg::ST_OK;
      rsp_data_in   = req_value;
      op_ok         = 1'b0;
      if (is_ins) begin
         if (list_empty) begin
            op_ok = 1'b1;
         end else if (list_full) begin
            rsp_status_in = ali_pkg::ST_FULL;
         end else if (pos_ext > cnt_ext) begin
            rsp_status_in = ali_pkg::ST_BADPOS;
         end else begin
            op_ok = 1'b1;
         end
      end else if (is_del) begin
         if (list_empty) begin
            rsp_status_in = ali_pkg::ST_EMPTY;
         end else if (!hit_chain[DEPTH]) begin
            rsp_status_in = ali_pkg::ST_NOTFOUND;
         end else begin
            op_ok = 1'b1;
         end
      end else begin
         // both remaining mode codes read
         if (list_empty) begin
            rsp_status_in = ali_pkg::ST_EMPTY;
            rsp_data_in   = '0;
         end else if (pos_ext >= cnt_ext) begin
            rsp_status_in = ali_pkg::ST_BADPOS;
            rsp_data_in   = '0;
         end else begin
            rsp_data_in   = entry_q[req_pos[IW-1:0]];
         end
      end
   end

   always_comb begin
      ctrl.ins_en = req_fire && is_ins && op_ok;
      ctrl.del_en = req_fire && is_del && op_ok;
      ctrl.value  = req_value;
      // an empty list always takes the value at slot zero
      ctrl.pos    = list_empty ? '0 : req_pos;
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins_en) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.del_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ali_pkg::DATA_W-1:0] left_entry;
      logic [ali_pkg::DATA_W-1:0] right_entry;

      assign cell_valid[i] = (CW'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_entry = entry_q[i];
      end else begin : g_mid_l
         assign left_entry = entry_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = entry_q[i];
      end else begin : g_mid_r
         assign right_entry = entry_q[i+1];
      end

      ali_cell #(
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_valid (cell_valid[i]),
         .left_entry (left_entry),
         .right_entry(right_entry),
         .hit_in     (hit_chain[i]),
         .hit_out    (hit_chain[i+1]),
         .entry      (entry_q[i])
      );
   end

   assign rsp_valid_in = req_fire ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{ali_pkg::RSP_PAD_W{1'b0}},
                        ali_pkg::COUNT_W'(rsp_count_ff),
                        rsp_data_ff,
                        rsp_status_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("list count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.ins_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("accepted insert did not grow the count");

   a_delete_has_match: assert property (@(posedge clock) disable iff (reset)
      ctrl.del_en |-> hit_chain[DEPTH] && !list_empty)
      else $error("delete applied without a live match");

   a_stall_holds_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(count_ff))
      else $error("count moved while the result was stalled");

endmodule

### verif/tb_array_list_insert_delete.sv
// testbench for the positional insert/delete list: directed table, then random traffic
`timescale 1ns / 1ps

module tb_array_list_insert_delete;

   localparam int LIST_DEPTH   = ali_pkg::DEFAULT_DEPTH;
   localparam int RANDOM_ITEMS = 1800;
   localparam int PHASE_LEN    = 150;
   localparam int DRAIN_CYCLES = 20;
   localparam int N_DIRECTED   = 21;

   typedef struct {
      ali_pkg::mode_type          mode;
      logic [ali_pkg::DATA_W-1:0] value;
      logic [ali_pkg::POS_W-1:0]  position;
   } list_request_type;

   typedef struct {
      ali_pkg::status_type         status;
      logic [ali_pkg::DATA_W-1:0]  data;
      logic [ali_pkg::COUNT_W-1:0] count;
   } list_result_type;

   typedef struct {
      ali_pkg::mode_type           mode;
      logic [ali_pkg::DATA_W-1:0]  value;
      logic [ali_pkg::POS_W-1:0]   position;
      int                          copies;
      bit                          fixed;
      ali_pkg::status_type         status;
      logic [ali_pkg::DATA_W-1:0]  data;
      logic [ali_pkg::COUNT_W-1:0] count;
   } directed_row_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ali_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ali_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // shadow copy of the list
   logic [ali_pkg::DATA_W-1:0] shadow_slots [LIST_DEPTH];
   int                         shadow_count;

   list_result_type  pending_results [$];
   directed_row_type directed_rows [N_DIRECTED];
   logic [ali_pkg::DATA_W-1:0] value_pool [8];
   int error_count;
   int req_wait_max;
   int rsp_wait_max;

   array_list_insert_delete #(.DEPTH(LIST_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1000000;
      $display("Test completed with failures");
      $finish;
   end

   // applies one request to the shadow list and returns what the block should answer
   function automatic list_result_type apply_to_list(input list_request_type rq);
      list_result_type rs;
      int i;
      int hit;
      rs.data = rq.value;
      case (rq.mode)
         ali_pkg::MODE_INSERT: begin
            if (shadow_count == 0) begin
               // position is ignored on an empty list
               shadow_slots[0] = rq.value;
               shadow_count = 1;
               rs.status = ali_pkg::ST_OK;
            end else if (shadow_count >= LIST_DEPTH) begin
               rs.status = ali_pkg::ST_FULL;
            end else if (int'(rq.position) > shadow_count) begin
               rs.status = ali_pkg::ST_BADPOS;
            end else begin
               for (i = shadow_count; i > int'(rq.position); i--)
                  shadow_slots[i] = shadow_slots[i-1];
               shadow_slots[rq.position] = rq.value;
               shadow_count++;
               rs.status = ali_pkg::ST_OK;
            end
         end
         ali_pkg::MODE_DELETE: begin
            if (shadow_count == 0) begin
               rs.status = ali_pkg::ST_EMPTY;
            end else begin
               hit = -1;
               for (i = 0; i < shadow_count; i++)
                  if (hit < 0 && shadow_slots[i] == rq.value)
                     hit = i;
               if (hit < 0) begin
                  rs.status = ali_pkg::ST_NOTFOUND;
               end else begin
                  for (i = hit; i + 1 < shadow_count; i++)
                     shadow_slots[i] = shadow_slots[i+1];
                  shadow_count--;
                  rs.status = ali_pkg::ST_OK;
               end
            end
         end
         default: begin
            // both read codes behave the same
            rs.data = '0;
            if (shadow_count == 0) begin
               rs.status = ali_pkg::ST_EMPTY;
            end else if (int'(rq.position) >= shadow_count) begin
               rs.status = ali_pkg::ST_BADPOS;
            end else begin
               rs.status = ali_pkg::ST_OK;
               rs.data = shadow_slots[rq.position];
            end
         end
      endcase
      rs.count = ali_pkg::COUNT_W'(shadow_count);
      return rs;
   endfunction

   // one request transaction; when use_fixed is set, fixed_result overrides the shadow list's answer
   task automatic send_request(input list_request_type rq, input bit use_fixed,
                               input list_result_type fixed_result);
      int gap;
      list_result_type rs;
      gap = $urandom_range(0, req_wait_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rq.position, rq.value, rq.mode};
      do @(negedge clock); while (!req_tready);
      rs = apply_to_list(rq);
      pending_results.push_back(use_fixed ? fixed_result : rs);
      @(posedge clock);
   endtask

   function automatic logic [ali_pkg::DATA_W-1:0] pick_value();
      if ($urandom_range(0, 99) < 40)
         return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic list_request_type random_request(input int ins_pct);
      list_request_type rq;
      int r;
      r = $urandom_range(0, 99);
      rq.value = pick_value();
      rq.position = ali_pkg::POS_W'($urandom_range(0, 63));
      if (r < ins_pct) begin
         rq.mode = ali_pkg::MODE_INSERT;
         if ($urandom_range(0, 99) < 85)
            rq.position = ali_pkg::POS_W'($urandom_range(0, shadow_count));
      end else if (r < 85) begin
         rq.mode = ali_pkg::MODE_DELETE;
         if (shadow_count > 0 && $urandom_range(0, 99) < 70)
            rq.value = shadow_slots[$urandom_range(0, shadow_count - 1)];
      end else begin
         rq.mode = (r < 97) ? ali_pkg::MODE_READ : ali_pkg::MODE_READ_ALT;
         if (shadow_count > 0 && $urandom_range(0, 99) < 80)
            rq.position = ali_pkg::POS_W'($urandom_range(0, shadow_count - 1));
      end
      return rq;
   endfunction

   // result side: random stall before each result, then check it at the falling edge once it is offered with ready high
   initial begin
      list_result_type got;
      list_result_type want;
      int stall;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_wait_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         got.status = ali_pkg::status_type'(rsp_tdata[ali_pkg::STATUS_W-1:0]);
         got.data   = rsp_tdata[ali_pkg::STATUS_W +: ali_pkg::DATA_W];
         got.count  = rsp_tdata[ali_pkg::STATUS_W + ali_pkg::DATA_W +: ali_pkg::COUNT_W];
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result: status %0d data %h count %0d",
                        got.status, got.data, got.count);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.data !== want.data ||
                got.count !== want.count) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected status %0d data %h count %0d, got %0d %h %0d",
                           want.status, want.data, want.count,
                           got.status, got.data, got.count);
            end
         end
         @(posedge clock);
      end
   end

   initial begin
      list_request_type rq;
      list_result_type fx;
      int n;
      int k;
      int guard;
      int ins_pct;

      error_count  = 0;
      shadow_count = 0;
      req_wait_max = 9;
      rsp_wait_max = 9;
      value_pool = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0007};

      // mode, value, position, copies, fixed, then status, data, count
      directed_rows = '{
         '{ali_pkg::MODE_READ,     32'h0000_0000, 6'd0,  1,  1'b1,
           ali_pkg::ST_EMPTY,    32'h0000_0000, 7'd0},
         '{ali_pkg::MODE_DELETE,   32'h0000_0005, 6'd0,  1,  1'b1,
           ali_pkg::ST_EMPTY,    32'h0000_0005, 7'd0},
         '{ali_pkg::MODE_INSERT,   32'h7FFF_FFFF, 6'd63, 1,  1'b1,
           ali_pkg::ST_OK,       32'h7FFF_FFFF, 7'd1},
         '{ali_pkg::MODE_INSERT,   32'h8000_0000, 6'd0,  1,  1'b1,
           ali_pkg::ST_OK,       32'h8000_0000, 7'd2},
         '{ali_pkg::MODE_INSERT,   32'h0000_0001, 6'd5,  1,  1'b1,
           ali_pkg::ST_BADPOS,   32'h0000_0001, 7'd2},
         '{ali_pkg::MODE_INSERT,   32'hFFFF_FFFF, 6'd2,  1,  1'b1,
           ali_pkg::ST_OK,       32'hFFFF_FFFF, 7'd3},
         '{ali_pkg::MODE_READ,     32'h0000_0000, 6'd0,  1,  1'b0,
           ali_pkg::ST_OK,       32'h0,         7'd0},
         '{ali_pkg::MODE_READ,     32'h0000_0000, 6'd3,  1,  1'b1,
           ali_pkg::ST_BADPOS,   32'h0000_0000, 7'd3},
         '{ali_pkg::MODE_READ_ALT, 32'h0000_0000, 6'd1,  1,  1'b0,
           ali_pkg::ST_OK,       32'h0,         7'd0},
         '{ali_pkg::MODE_DELETE,   32'h0000_04D2, 6'd0,  1,  1'b1,
           ali_pkg::ST_NOTFOUND, 32'h0000_04D2, 7'd3},
         '{ali_pkg::MODE_DELETE,   32'h7FFF_FFFF, 6'd0,  1,  1'b1,
           ali_pkg::ST_OK,       32'h7FFF_FFFF, 7'd2},
         '{ali_pkg::MODE_INSERT,   32'h5555_5555, 6'd1,  14, 1'b0,
           ali_pkg::ST_OK,       32'h0,         7'd0},
         '{ali_pkg::MODE_INSERT,   32'hAAAA_AAAA, 6'd0,  1,  1'b1,
           ali_pkg::ST_FULL,     32'hAAAA_AAAA, 7'd16},
         '{ali_pkg::MODE_READ,     32'h0000_0000, 6'd15, 1,  1'b0,
           ali_pkg::ST_OK,       32'h0,         7'd0},
         '{ali_pkg::MODE_READ,     32'h0000_0000, 6'd16, 1,  1'b1,
           ali_pkg::ST_BADPOS,   32'h0000_0000, 7'd16},
         '{ali_pkg::MODE_READ,     32'hFFFF_FFFF, 6'd63, 1,  1'b1,
           ali_pkg::ST_BADPOS,   32'h0000_0000, 7'd16},
         '{ali_pkg::MODE_DELETE,   32'h5555_5555, 6'd0,  1,  1'b1,
           ali_pkg::ST_OK,       32'h5555_5555, 7'd15},
         '{ali_pkg::MODE_INSERT,   32'h0000_0000, 6'd15, 1,  1'b0,
           ali_pkg::ST_OK,       32'h0,         7'd0},
         '{ali_pkg::MODE_READ_ALT, 32'h0000_0000, 6'd15, 1,  1'b0,
           ali_pkg::ST_OK,       32'h0,         7'd0},
         '{ali_pkg::MODE_DELETE,   32'h0000_0000, 6'd0,  1,  1'b0,
           ali_pkg::ST_OK,       32'h0,         7'd0},
         '{ali_pkg::MODE_INSERT,   32'hAAAA_AAAA, 6'd0,  1,  1'b0,
           ali_pkg::ST_OK,       32'h0,         7'd0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         rq.mode     = directed_rows[r].mode;
         rq.value    = directed_rows[r].value;
         rq.position = directed_rows[r].position;
         fx.status   = directed_rows[r].status;
         fx.data     = directed_rows[r].data;
         fx.count    = directed_rows[r].count;
         for (k = 0; k < directed_rows[r].copies; k++)
            send_request(rq, directed_rows[r].fixed, fx);
      end

      // alternate between filling and draining phases, with changing idle depth
      ins_pct = 65;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_LEN == 0) begin
            ins_pct = (ins_pct == 65) ? 25 : 65;
            k = $urandom_range(0, 2);
            req_wait_max = (k == 0) ? 0 : (k == 1) ? 3 : 9;
            k = $urandom_range(0, 2);
            rsp_wait_max = (k == 0) ? 0 : (k == 1) ? 3 : 9;
         end
         rq = random_request(ins_pct);
         send_request(rq, 1'b0, fx);
      end
      req_tvalid <= 1'b0;

      guard = 0;
      while (pending_results.size() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         error_count++;

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
